// File: rtl/assert_macros.svh
// Assertion macros used by the top level of the scheduler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/rrts_pkg.sv
// Types, constants and helper functions of the round-robin thread scheduler
package rrts_pkg;

    localparam int TASKS  = 32;
    localparam int TASK_W = $clog2(TASKS);
    localparam int CNT_W  = $clog2(TASKS + 1);

    localparam int ID_W   = 5;
    localparam int OP_W   = 3;
    localparam int PRIO_W = 8;
    localparam int KIND_W = 3;
    localparam int ST_W   = 3;
    localparam int ERR_W  = 2;

    localparam logic [PRIO_W-1:0] TOP_PRIORITY = 8'd31;
    localparam logic [ID_W-1:0]   IDLE_RESET   = 5'd1;

    typedef logic [TASK_W-1:0] tid_t;

    typedef enum logic [ST_W-1:0] {
        ST_RUNNING = 3'd0,
        ST_READY   = 3'd1,
        ST_BLOCKED = 3'd2,
        ST_WAITING = 3'd3,
        ST_HANGING = 3'd4,
        ST_DEAD    = 3'd5
    } task_status_t;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_PREEMPT = 3'd1,
        OP_YIELD   = 3'd2,
        OP_BLOCK   = 3'd3,
        OP_UNBLOCK = 3'd4,
        OP_EXIT    = 3'd5
    } op_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 2'd0,
        ERR_UNBLOCK = 2'd1,
        ERR_CREATE  = 2'd2,
        ERR_IDLE    = 2'd3
    } err_t;

    // Commands broadcast along the ready-deque cell chain
    typedef enum logic [2:0] {
        Q_NONE      = 3'd0,
        Q_PUSH_TAIL = 3'd1,
        Q_PUSH_HEAD = 3'd2,
        Q_REMOVE    = 3'd3,
        Q_POP       = 3'd4
    } q_kind_t;

    typedef struct packed {
        q_kind_t kind;
        tid_t    id;
    } q_cmd_t;

    typedef struct packed {
        logic             empty;
        logic [CNT_W-1:0] count;
        tid_t             head;
    } q_stat_t;

    // Task table access: one read address, one write port per field
    typedef struct packed {
        logic              st_we;
        tid_t              st_addr;
        task_status_t      st_data;
        logic              pr_we;
        tid_t              pr_addr;
        logic [PRIO_W-1:0] pr_data;
        logic              sl_we;
        tid_t              sl_addr;
        logic [PRIO_W-1:0] sl_data;
        tid_t              rd_addr;
    } tt_req_t;

    typedef struct packed {
        task_status_t      status;
        logic [PRIO_W-1:0] prio;
        logic [PRIO_W-1:0] slice;
    } tt_rsp_t;

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return (int'(id) < TASKS);
    endfunction

    function automatic logic is_waiting(input task_status_t s);
        return (s == ST_BLOCKED) || (s == ST_WAITING) || (s == ST_HANGING);
    endfunction

    function automatic task_status_t reset_status(input tid_t a);
        return (a == '0) ? ST_RUNNING : ST_DEAD;
    endfunction

    function automatic logic [PRIO_W-1:0] reset_prio(input tid_t a);
        return (a == '0) ? TOP_PRIORITY : '0;
    endfunction

endpackage

// File: rtl/rrts_if.sv
// Handshake channel interfaces of the scheduler: command, response, configuration
interface rrts_in_if;
    import rrts_pkg::*;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] priority_req;
    logic [KIND_W-1:0] block_kind;
    logic              need_switch;

    modport source (output valid, output op, output task_id, output priority_req,
                    output block_kind, output need_switch, input ready);
    modport sink (input valid, input op, input task_id, input priority_req,
                  input block_kind, input need_switch, output ready);
endinterface

interface rrts_out_if;
    import rrts_pkg::*;
    logic              valid;
    logic              ready;
    logic              switched;
    logic [ID_W-1:0]   next_task;
    logic [PRIO_W-1:0] slice_ticks;
    logic [ERR_W-1:0]  error;

    modport source (output valid, output switched, output next_task, output slice_ticks,
                    output error, input ready);
    modport sink (input valid, input switched, input next_task, input slice_ticks,
                  input error, output ready);
endinterface

interface rrts_cfg_if;
    import rrts_pkg::*;
    logic            valid;
    logic            ready;
    logic [ID_W-1:0] idle_task;

    modport source (output valid, output idle_task, input ready);
    modport sink (input valid, input idle_task, output ready);
endinterface

// File: rtl/rrts_ram.sv
// Generic single-write, single-read RAM with registered read data
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/rrts_task_table.sv
// Per-task status, priority and slice store with reset-value valid bits
module rrts_task_table (
    input  logic              clk,
    input  logic              rst_n,
    input  rrts_pkg::tt_req_t req,
    output rrts_pkg::tt_rsp_t rsp
);
    import rrts_pkg::*;

    logic [TASKS-1:0]  st_valid_reg;
    logic [TASKS-1:0]  pr_valid_reg;
    logic [TASKS-1:0]  sl_valid_reg;
    logic              st_hit_reg;
    logic              pr_hit_reg;
    logic              sl_hit_reg;
    tid_t              rd_addr_reg;
    logic [ST_W-1:0]   st_raw;
    logic [PRIO_W-1:0] pr_raw;
    logic [PRIO_W-1:0] sl_raw;

    rrts_ram #(.WIDTH(ST_W), .DEPTH(TASKS)) u_status_ram (
        .clk     (clk),
        .wr_en   (req.st_we),
        .wr_addr (req.st_addr),
        .wr_data (req.st_data),
        .rd_addr (req.rd_addr),
        .rd_data (st_raw)
    );

    rrts_ram #(.WIDTH(PRIO_W), .DEPTH(TASKS)) u_prio_ram (
        .clk     (clk),
        .wr_en   (req.pr_we),
        .wr_addr (req.pr_addr),
        .wr_data (req.pr_data),
        .rd_addr (req.rd_addr),
        .rd_data (pr_raw)
    );

    rrts_ram #(.WIDTH(PRIO_W), .DEPTH(TASKS)) u_slice_ram (
        .clk     (clk),
        .wr_en   (req.sl_we),
        .wr_addr (req.sl_addr),
        .wr_data (req.sl_data),
        .rd_addr (req.rd_addr),
        .rd_data (sl_raw)
    );

    // Mark entries written; register the mark alongside the read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= '0;
            pr_valid_reg <= '0;
            sl_valid_reg <= '0;
            st_hit_reg   <= 1'b0;
            pr_hit_reg   <= 1'b0;
            sl_hit_reg   <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (req.st_we)
            begin
                st_valid_reg[req.st_addr] <= 1'b1;
            end
            if (req.pr_we)
            begin
                pr_valid_reg[req.pr_addr] <= 1'b1;
            end
            if (req.sl_we)
            begin
                sl_valid_reg[req.sl_addr] <= 1'b1;
            end
            st_hit_reg  <= st_valid_reg[req.rd_addr];
            pr_hit_reg  <= pr_valid_reg[req.rd_addr];
            sl_hit_reg  <= sl_valid_reg[req.rd_addr];
            rd_addr_reg <= req.rd_addr;
        end
    end

    assign rsp.status = st_hit_reg ? task_status_t'(st_raw) : reset_status(rd_addr_reg);
    assign rsp.prio   = pr_hit_reg ? pr_raw : reset_prio(rd_addr_reg);
    assign rsp.slice  = sl_hit_reg ? sl_raw : reset_prio(rd_addr_reg);

endmodule

// File: rtl/rrts_queue_cell.sv
// One position of the ready deque: holds a task number, shifts with its neighbours
module rrts_queue_cell (
    input  logic             clk,
    input  rrts_pkg::q_cmd_t cmd,
    input  logic             present,
    input  logic             at_tail,
    input  logic             valid,
    input  rrts_pkg::tid_t   left_entry,
    input  rrts_pkg::tid_t   right_entry,
    input  logic             hit_in,
    output logic             hit_out,
    output rrts_pkg::tid_t   entry
);
    import rrts_pkg::*;

    tid_t entry_reg;
    tid_t entry_next;
    logic match;

    assign match   = valid && (entry_reg == cmd.id);
    // Carry: set from the matching cell towards the tail
    assign hit_out = hit_in || match;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.kind)
            Q_PUSH_TAIL:
            begin
                if (!present && at_tail)
                begin
                    entry_next = cmd.id;
                end
            end
            Q_PUSH_HEAD:
            begin
                if (!present)
                begin
                    entry_next = left_entry;
                end
            end
            Q_REMOVE:
            begin
                if (present && hit_out)
                begin
                    entry_next = right_entry;
                end
            end
            Q_POP:
            begin
                entry_next = right_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/rrts_ready_queue.sv
// Ready deque built as a row of shifting cells with a fill count
module rrts_ready_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  rrts_pkg::q_cmd_t  cmd,
    output rrts_pkg::q_stat_t stat
);
    import rrts_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [TASKS:0]   hit_chain;
    tid_t             entry_q [TASKS];
    q_cmd_t           cmd_eff;
    logic             present;
    logic             full;
    logic             empty;

    assign full      = (count_reg == CNT_W'(TASKS));
    assign empty     = (count_reg == '0);
    assign present   = hit_chain[TASKS];
    assign hit_chain[0] = 1'b0;

    // Drop pushes into a full deque and pops from an empty one
    always_comb
    begin
        cmd_eff = cmd;
        case (cmd.kind)
            Q_PUSH_TAIL, Q_PUSH_HEAD:
            begin
                if (full)
                begin
                    cmd_eff.kind = Q_NONE;
                end
            end
            Q_POP:
            begin
                if (empty)
                begin
                    cmd_eff.kind = Q_NONE;
                end
            end
            default:
            begin
                cmd_eff = cmd;
            end
        endcase
    end

    generate
        for (genvar i = 0; i < TASKS; i++)
        begin : g_cell
            tid_t left_entry;
            tid_t right_entry;

            if (i == 0)
            begin : g_head
                assign left_entry = cmd_eff.id;
            end
            else
            begin : g_body
                assign left_entry = entry_q[i-1];
            end

            if (i == TASKS - 1)
            begin : g_last
                assign right_entry = '0;
            end
            else
            begin : g_inner
                assign right_entry = entry_q[i+1];
            end

            rrts_queue_cell u_cell (
                .clk         (clk),
                .cmd         (cmd_eff),
                .present     (present),
                .at_tail     (count_reg == CNT_W'(i)),
                .valid       (CNT_W'(i) < count_reg),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .hit_in      (hit_chain[i]),
                .hit_out     (hit_chain[i+1]),
                .entry       (entry_q[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        case (cmd_eff.kind)
            Q_PUSH_TAIL, Q_PUSH_HEAD:
            begin
                if (!present)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            Q_REMOVE:
            begin
                if (present)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            Q_POP:
            begin
                count_next = count_reg - 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.empty = empty;
    assign stat.count = count_reg;
    assign stat.head  = entry_q[0];

endmodule

// File: rtl/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler: control sequencer, task table, ready deque
//
// Usage: the command channel (cmd) carries one scheduling transaction: create, preempt,
// yield, block, unblock or exit, with a task number, priority, wait kind and, for exit,
// whether a new task is to be picked. Each command yields exactly one response transaction
// on rsp: switched flag, running task, its remaining slice and an error code. The cfg
// channel writes the idle task number and is always ready; the user must write it only
// while no command is in flight, which the block itself does not enforce.
// Timing: one command at a time. A command is accepted in S_IDLE and passes S_EXEC; then
// preempt passes S_SW_POP or S_SW_IDLE, and yield, block and exit with a switch pass
// S_SW_READ, S_SW_CUR, then S_SW_POP or S_SW_IDLE. Every command then passes S_FIN_READ
// and loads its response into the output register from S_DONE; a new command is taken in
// S_IDLE after that load. The steps come from the single read port of the task table,
// whose read data is registered, and the sequencer visiting it once per step.
// Reset: task 0 is running with priority and slice 31, every other task is dead, the ready
// deque is empty and the idle task is 1. No clearing pass is needed.
// Stall: the response waits in the output register; a new command is still accepted and
// worked on, and its response is held back until the previous one has been taken.
`include "assert_macros.svh"

module round_robin_thread_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    rrts_in_if.sink     cmd,
    rrts_out_if.source  rsp,
    rrts_cfg_if.sink    cfg
);
    import rrts_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_EXEC     = 8'b0000_0010,
        S_SW_READ  = 8'b0000_0100,
        S_SW_CUR   = 8'b0000_1000,
        S_SW_IDLE  = 8'b0001_0000,
        S_SW_POP   = 8'b0010_0000,
        S_FIN_READ = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;

    // Latched command fields
    logic [OP_W-1:0]   op_reg;
    tid_t              id_reg;
    logic              id_ok_reg;
    logic [PRIO_W-1:0] prio_reg;
    task_status_t      kind_reg;
    logic              need_reg;

    // Scheduler state and per-command results
    tid_t              running_reg;
    tid_t              running_next;
    logic [ID_W-1:0]   idle_reg;
    err_t              err_reg;
    err_t              err_next;
    logic              sw_reg;
    logic              sw_next;
    task_status_t      old_st_reg;
    task_status_t      old_st_next;

    // Output register
    logic              out_valid_reg;
    logic              out_sw_reg;
    logic [ID_W-1:0]   out_task_reg;
    logic [PRIO_W-1:0] out_slice_reg;
    err_t              out_err_reg;
    logic              out_load;

    logic              accept;
    logic              cur_check;
    logic              idle_ok;
    task_status_t      kind_in;

    tt_req_t           tt_req;
    tt_rsp_t           tt_rsp;
    q_cmd_t            q_cmd;
    q_stat_t           q_stat;

    rrts_task_table u_task_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tt_req),
        .rsp   (tt_rsp)
    );

    rrts_ready_queue u_ready_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .stat  (q_stat)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;
    assign idle_ok   = id_in_range(idle_reg);

    // Fold wait kinds outside blocked..hanging onto blocked
    assign kind_in = ((cmd.block_kind >= KIND_W'(ST_BLOCKED))
                      && (cmd.block_kind <= KIND_W'(ST_HANGING)))
                     ? task_status_t'(cmd.block_kind) : ST_BLOCKED;

    // Sequencer: one task-table access and at most one deque command per step
    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        err_next     = err_reg;
        sw_next      = sw_reg;
        old_st_next  = old_st_reg;
        out_load     = 1'b0;
        cur_check    = 1'b0;
        tt_req       = '0;
        tt_req.rd_addr = running_reg;
        q_cmd        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    // Fetch the entry the command looks at first
                    if ((cmd.op == OP_CREATE) || (cmd.op == OP_UNBLOCK))
                    begin
                        tt_req.rd_addr = TASK_W'(cmd.task_id);
                    end
                    err_next   = ERR_NONE;
                    sw_next    = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_FIN_READ;
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (id_ok_reg)
                        begin
                            if (tt_rsp.status != ST_DEAD)
                            begin
                                err_next = ERR_CREATE;
                            end
                            else
                            begin
                                tt_req.st_we   = 1'b1;
                                tt_req.st_addr = id_reg;
                                tt_req.st_data = ST_READY;
                                tt_req.pr_we   = 1'b1;
                                tt_req.pr_addr = id_reg;
                                tt_req.pr_data = prio_reg;
                                tt_req.sl_we   = 1'b1;
                                tt_req.sl_addr = id_reg;
                                tt_req.sl_data = prio_reg;
                                q_cmd.kind     = Q_PUSH_TAIL;
                                q_cmd.id       = id_reg;
                            end
                        end
                    end
                    OP_PREEMPT:
                    begin
                        cur_check = 1'b1;
                    end
                    OP_YIELD:
                    begin
                        tt_req.st_we   = 1'b1;
                        tt_req.st_addr = running_reg;
                        tt_req.st_data = ST_READY;
                        q_cmd.kind     = Q_PUSH_TAIL;
                        q_cmd.id       = running_reg;
                        state_next     = S_SW_READ;
                    end
                    OP_BLOCK:
                    begin
                        // Keep the old status in case no task can run
                        old_st_next    = tt_rsp.status;
                        tt_req.st_we   = 1'b1;
                        tt_req.st_addr = running_reg;
                        tt_req.st_data = kind_reg;
                        state_next     = S_SW_READ;
                    end
                    OP_UNBLOCK:
                    begin
                        if (id_ok_reg)
                        begin
                            if (is_waiting(tt_rsp.status))
                            begin
                                tt_req.st_we   = 1'b1;
                                tt_req.st_addr = id_reg;
                                tt_req.st_data = ST_READY;
                                q_cmd.kind     = Q_PUSH_HEAD;
                                q_cmd.id       = id_reg;
                            end
                            else
                            begin
                                err_next = ERR_UNBLOCK;
                            end
                        end
                    end
                    OP_EXIT:
                    begin
                        if (id_ok_reg)
                        begin
                            tt_req.st_we   = 1'b1;
                            tt_req.st_addr = id_reg;
                            tt_req.st_data = ST_DEAD;
                            q_cmd.kind     = Q_REMOVE;
                            q_cmd.id       = id_reg;
                            if (need_reg)
                            begin
                                state_next = S_SW_READ;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN_READ;
                    end
                endcase
            end

            S_SW_READ:
            begin
                state_next = S_SW_CUR;
            end

            S_SW_CUR:
            begin
                cur_check = 1'b1;
            end

            S_SW_IDLE:
            begin
                state_next = S_FIN_READ;
                if (idle_ok && is_waiting(tt_rsp.status))
                begin
                    // Push idle at the head and pop it at once: the deque is unchanged
                    tt_req.st_we   = 1'b1;
                    tt_req.st_addr = TASK_W'(idle_reg);
                    tt_req.st_data = ST_RUNNING;
                    running_next   = TASK_W'(idle_reg);
                    sw_next        = 1'b1;
                end
                else
                begin
                    err_next = ERR_IDLE;
                    if (op_reg == OP_BLOCK)
                    begin
                        // Undo the block
                        tt_req.st_we   = 1'b1;
                        tt_req.st_addr = running_reg;
                        tt_req.st_data = old_st_reg;
                    end
                end
            end

            S_SW_POP:
            begin
                tt_req.st_we   = 1'b1;
                tt_req.st_addr = q_stat.head;
                tt_req.st_data = ST_RUNNING;
                q_cmd.kind     = Q_POP;
                running_next   = q_stat.head;
                sw_next        = 1'b1;
                state_next     = S_FIN_READ;
            end

            S_FIN_READ:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Pop the head, requeueing a running task first; on an empty deque use the idle task
        if (cur_check)
        begin
            if (tt_rsp.status == ST_RUNNING)
            begin
                tt_req.st_we   = 1'b1;
                tt_req.st_addr = running_reg;
                tt_req.st_data = ST_READY;
                tt_req.sl_we   = 1'b1;
                tt_req.sl_addr = running_reg;
                tt_req.sl_data = tt_rsp.prio;
                q_cmd.kind     = Q_PUSH_TAIL;
                q_cmd.id       = running_reg;
                state_next     = S_SW_POP;
            end
            else if (!q_stat.empty)
            begin
                state_next = S_SW_POP;
            end
            else
            begin
                tt_req.rd_addr = TASK_W'(idle_reg);
                state_next     = S_SW_IDLE;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            running_reg   <= '0;
            idle_reg      <= IDLE_RESET;
            err_reg       <= ERR_NONE;
            sw_reg        <= 1'b0;
            old_st_reg    <= ST_RUNNING;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            err_reg     <= err_next;
            sw_reg      <= sw_next;
            old_st_reg  <= old_st_next;
            if (cfg.valid)
            begin
                idle_reg <= cfg.idle_task;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Command fields and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= cmd.op;
            id_reg    <= TASK_W'(cmd.task_id);
            id_ok_reg <= id_in_range(cmd.task_id);
            prio_reg  <= cmd.priority_req;
            kind_reg  <= kind_in;
            need_reg  <= cmd.need_switch;
        end
        if (out_load)
        begin
            out_sw_reg    <= sw_reg;
            out_task_reg  <= ID_W'(running_reg);
            out_slice_reg <= tt_rsp.slice;
            out_err_reg   <= err_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.switched    = out_sw_reg;
    assign rsp.next_task   = out_task_reg;
    assign rsp.slice_ticks = out_slice_reg;
    assign rsp.error       = out_err_reg;

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, q_stat.count <= CNT_W'(TASKS), "ready deque count exceeds the number of tasks")
    `ASSERT_IMPLIES(a_pop_nonempty, clk, rst_n, state_reg == S_SW_POP, !q_stat.empty, "switch pops an empty ready deque")
    `ASSERT_NEXT(a_result_loaded, clk, rst_n, out_load, rsp.valid, "response not presented after load")
    `ASSERT_IMPLIES(a_err_no_switch, clk, rst_n, rsp.valid, !(rsp.switched && (rsp.error != ERR_NONE)), "switch reported together with an error")

endmodule

// File: tb/round_robin_thread_scheduler_tb.sv
// Self-checking testbench of the round-robin thread scheduler: shadow task table, response checks
`timescale 1ns / 1ps

module round_robin_thread_scheduler_tb;
    import rrts_pkg::*;

    // Op codes the block does not define; it must answer them with the current task
    localparam logic [OP_W-1:0]   OP_SPARE_A        = 3'd6;
    localparam logic [OP_W-1:0]   OP_SPARE_B        = 3'd7;
    // A wait kind that is no wait status at all; the block treats it as blocked
    localparam logic [KIND_W-1:0] KIND_OUT_OF_RANGE = 3'd7;
    localparam int                RANDOM_IDLE       = -1;
    localparam int                PHASES            = 8;
    localparam int                PHASE_ITEMS       = 200;
    localparam int                RX_HOLD           = 400;  // long receiver hold-off
    localparam int                QUIET_LIMIT       = 2000; // cycles without any transaction
    localparam int                TAIL_CYCLES       = 12;   // slowest command plus margin

    typedef struct packed {
        logic [OP_W-1:0]   op;
        tid_t              task_id;
        logic [PRIO_W-1:0] priority_req;
        logic [KIND_W-1:0] block_kind;
        logic              need_switch;
    } sched_cmd_t;

    typedef struct packed {
        logic              switched;
        tid_t              next_task;
        logic [PRIO_W-1:0] slice_ticks;
        err_t              error;
    } dispatch_t;

    // Shadow of the scheduler: task table, ready deque and running task, plus the
    // dispatch outcomes still owed by the block, oldest first.
    class scheduler_scoreboard;
        task_status_t      status_of[TASKS];
        logic [PRIO_W-1:0] prio_of[TASKS];
        logic [PRIO_W-1:0] slice_of[TASKS];
        tid_t              ready_deque[$];
        tid_t              running;
        tid_t              idle;
        dispatch_t         dispatch_q[$];
        int                mismatches;
        int                answered;

        function new();
            for (int t = 0; t < TASKS; t++)
            begin
                if (t == 0)
                begin
                    status_of[t] = ST_RUNNING;
                    prio_of[t]   = TOP_PRIORITY;
                end
                else
                begin
                    status_of[t] = ST_DEAD;
                    prio_of[t]   = '0;
                end
                slice_of[t] = prio_of[t];
            end
            running    = '0;
            idle       = IDLE_RESET;
            mismatches = 0;
            answered   = 0;
        endfunction

        function void set_idle(tid_t t);
            idle = t;
        endfunction

        function int pending();
            return dispatch_q.size();
        endfunction

        function int deque_pos(tid_t t);
            foreach (ready_deque[i])
                if (ready_deque[i] == t)
                    return i;
            return -1;
        endfunction

        // A task already queued stays where it is
        function void push_tail(tid_t t);
            if (deque_pos(t) < 0)
                ready_deque.push_back(t);
        endfunction

        function void push_head(tid_t t);
            if (deque_pos(t) < 0)
                ready_deque.push_front(t);
        endfunction

        function logic waiting(tid_t t);
            return status_of[t] inside {ST_BLOCKED, ST_WAITING, ST_HANGING};
        endfunction

        // Requeue a still-running task with a fresh slice, fall back to the idle task on
        // an empty deque, then pop the head. Nothing changes when nothing can run.
        function err_t dispatch_next();
            tid_t cur;
            tid_t nxt;
            cur = running;
            if (status_of[cur] == ST_RUNNING)
            begin
                push_tail(cur);
                slice_of[cur]  = prio_of[cur];
                status_of[cur] = ST_READY;
            end
            if (ready_deque.size() == 0)
            begin
                if (!waiting(idle))
                    return ERR_IDLE;
                push_head(idle);
                status_of[idle] = ST_READY;
            end
            nxt            = ready_deque.pop_front();
            status_of[nxt] = ST_RUNNING;
            running        = nxt;
            return ERR_NONE;
        endfunction

        function void schedule_op(sched_cmd_t c);
            err_t              err;
            logic              sw;
            tid_t              cur;
            tid_t              id;
            task_status_t      prev;
            logic [KIND_W-1:0] kind;
            int                pos;
            dispatch_t         d;
            err  = ERR_NONE;
            sw   = 1'b0;
            cur  = running;
            id   = c.task_id;
            kind = c.block_kind;
            case (c.op)
                OP_CREATE:
                begin
                    if (status_of[id] != ST_DEAD)
                        err = ERR_CREATE;
                    else
                    begin
                        status_of[id] = ST_READY;
                        prio_of[id]   = c.priority_req;
                        slice_of[id]  = c.priority_req;
                        push_tail(id);
                    end
                end
                OP_PREEMPT:
                begin
                    err = dispatch_next();
                    sw  = (err == ERR_NONE);
                end
                OP_YIELD:
                begin
                    push_tail(cur);
                    status_of[cur] = ST_READY;
                    err = dispatch_next();
                    sw  = (err == ERR_NONE);
                end
                OP_BLOCK:
                begin
                    if (!(kind inside {ST_BLOCKED, ST_WAITING, ST_HANGING}))
                        kind = ST_BLOCKED;
                    prev           = status_of[cur];
                    status_of[cur] = task_status_t'(kind);
                    err = dispatch_next();
                    if (err != ERR_NONE)
                        status_of[cur] = prev;
                    sw  = (err == ERR_NONE);
                end
                OP_UNBLOCK:
                begin
                    if (!waiting(id))
                        err = ERR_UNBLOCK;
                    else
                    begin
                        push_head(id);
                        status_of[id] = ST_READY;
                    end
                end
                OP_EXIT:
                begin
                    status_of[id] = ST_DEAD;
                    pos = deque_pos(id);
                    if (pos >= 0)
                        ready_deque.delete(pos);
                    if (c.need_switch)
                    begin
                        err = dispatch_next();
                        sw  = (err == ERR_NONE);
                    end
                end
                default: ;
            endcase
            d.switched    = sw;
            d.next_task   = running;
            d.slice_ticks = slice_of[running];
            d.error       = err;
            dispatch_q.push_back(d);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch on response %0d: %s", $time, answered, msg);
            mismatches++;
        endtask

        task check_response(dispatch_t got);
            dispatch_t want;
            answered++;
            if (dispatch_q.size() == 0)
            begin
                report("response with no command outstanding");
                return;
            end
            want = dispatch_q.pop_front();
            if (got.switched !== want.switched)
                report($sformatf("switched %0b, expected %0b", got.switched, want.switched));
            if (got.next_task !== want.next_task)
                report($sformatf("next_task %0d, expected %0d", got.next_task, want.next_task));
            if (got.slice_ticks !== want.slice_ticks)
                report($sformatf("slice_ticks %0d, expected %0d",
                                 got.slice_ticks, want.slice_ticks));
            if (got.error !== want.error)
                report($sformatf("error %0d, expected %0d", got.error, want.error));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rrts_in_if  cmd_ch ();
    rrts_out_if rsp_ch ();
    rrts_cfg_if cfg_ch ();

    scheduler_scoreboard sb = new();

    bit        tx_jitter = 1'b1;
    bit        rx_jitter = 1'b1;
    bit        hold_req  = 1'b0;
    int        pool_base = 0;
    int        pool_n    = TASKS;
    int        quiet_cycles;
    dispatch_t seen_rsp;

    round_robin_thread_scheduler dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Gap lengths: mostly none or a few cycles, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic sched_cmd_t sched_cmd(logic [OP_W-1:0] op, tid_t id,
                                             logic [PRIO_W-1:0] prio,
                                             logic [KIND_W-1:0] kind, logic need);
        sched_cmd_t c;
        c.op           = op;
        c.task_id      = id;
        c.priority_req = prio;
        c.block_kind   = kind;
        c.need_switch  = need;
        return c;
    endfunction

    // Steer the task number towards one the operation can act on: dead tasks for
    // create, waiting ones for unblock, live ones (often the running one) for exit.
    // The rest of the time any task goes, so the error paths stay busy too.
    function automatic tid_t pick_task(logic [OP_W-1:0] op);
        tid_t cand[$];
        int   r;
        logic ok;
        r = $urandom_range(0, 99);
        if (op == OP_EXIT && r < 15)
            return sb.running;
        if (r < 75 && op inside {OP_CREATE, OP_UNBLOCK, OP_EXIT})
        begin
            for (int t = 0; t < TASKS; t++)
            begin
                ok = (op == OP_CREATE)  ? (sb.status_of[t] == ST_DEAD) :
                     (op == OP_UNBLOCK) ? sb.waiting(tid_t'(t)) :
                                          (sb.status_of[t] != ST_DEAD);
                if (ok && ((t - pool_base + TASKS) % TASKS) < pool_n)
                    cand.push_back(tid_t'(t));
            end
            if (cand.size() != 0)
                return cand[$urandom_range(0, cand.size() - 1)];
        end
        return tid_t'($urandom_range(0, TASKS - 1));
    endfunction

    // Offer one command, hold it until the block takes it, then note the transaction
    // and maybe drop valid for a while. With no gap, valid stays high for the next one.
    task automatic send(sched_cmd_t c);
        int gap;
        cmd_ch.valid        <= 1'b1;
        cmd_ch.op           <= c.op;
        cmd_ch.task_id      <= c.task_id;
        cmd_ch.priority_req <= c.priority_req;
        cmd_ch.block_kind   <= c.block_kind;
        cmd_ch.need_switch  <= c.need_switch;
        do @(posedge clk); while (!cmd_ch.ready);
        sb.schedule_op(c);
        gap = tx_jitter ? gap_len() : 0;
        if (gap != 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random();
        sched_cmd_t c;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 20)
            c.op = OP_CREATE;
        else if (r < 38)
            c.op = OP_PREEMPT;
        else if (r < 52)
            c.op = OP_YIELD;
        else if (r < 66)
            c.op = OP_BLOCK;
        else if (r < 84)
            c.op = OP_UNBLOCK;
        else if (r < 97)
            c.op = OP_EXIT;
        else
            c.op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        c.task_id = pick_task(c.op);
        r = $urandom_range(0, 99);
        c.priority_req = (r < 8) ? '0 : (r < 16) ? '1 : PRIO_W'($urandom_range(0, 255));
        c.block_kind   = ($urandom_range(0, 4) != 0) ?
                         KIND_W'($urandom_range(ST_BLOCKED, ST_HANGING)) :
                         KIND_W'($urandom_range(0, 7));
        c.need_switch  = 1'($urandom_range(0, 1));
        send(c);
    endtask

    // Drop valid and wait until every response owed has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_idle(tid_t t);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.idle_task <= t;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_idle(t);
        cfg_ch.valid <= 1'b0;
    endtask

    // Directed walk from reset with idle task 1: empty-deque fallbacks, the idle
    // task not waiting, unused codes, odd wait kinds, double create and unblock, a
    // running task that exits and is recreated while still running, removal from the
    // middle of the deque.
    task automatic directed_walk();
        send(sched_cmd(OP_PREEMPT, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_BLOCK, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_SPARE_A, 5'd0, 8'd0, ST_RUNNING, 1'b0));
        send(sched_cmd(OP_SPARE_B, 5'd31, 8'd255, KIND_OUT_OF_RANGE, 1'b1));
        send(sched_cmd(OP_CREATE, 5'd31, 8'd255, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_CREATE, 5'd31, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_CREATE, 5'd1, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_UNBLOCK, 5'd5, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_YIELD, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_BLOCK, 5'd0, 8'd0, ST_RUNNING, 1'b0));
        send(sched_cmd(OP_BLOCK, 5'd0, 8'd0, KIND_OUT_OF_RANGE, 1'b0));
        send(sched_cmd(OP_BLOCK, 5'd0, 8'd0, ST_WAITING, 1'b0));
        send(sched_cmd(OP_BLOCK, 5'd0, 8'd0, ST_HANGING, 1'b0));
        send(sched_cmd(OP_UNBLOCK, 5'd31, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_UNBLOCK, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_UNBLOCK, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_EXIT, 5'd1, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_CREATE, 5'd1, 8'h55, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_YIELD, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_CREATE, 5'd2, 8'hAA, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_EXIT, 5'd1, 8'd0, ST_BLOCKED, 1'b1));
        send(sched_cmd(OP_EXIT, 5'd31, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_PREEMPT, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
        send(sched_cmd(OP_EXIT, 5'd2, 8'd0, ST_BLOCKED, 1'b1));
        send(sched_cmd(OP_PREEMPT, 5'd0, 8'd0, ST_BLOCKED, 1'b0));
    endtask

    // Response side: random stalls, or a long hold-off when asked for one. The hold is
    // counted here so the sender keeps offering while the block backs up.
    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
                hold_req = 1'b0;
            end
            if (stall == 0 && rx_jitter && $urandom_range(0, 3) == 0)
                stall = gap_len();
            if (stall != 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Check every response transaction against the oldest outcome owed
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen_rsp.switched    = rsp_ch.switched;
            seen_rsp.next_task   = rsp_ch.next_task;
            seen_rsp.slice_ticks = rsp_ch.slice_ticks;
            seen_rsp.error       = err_t'(rsp_ch.error);
            sb.check_response(seen_rsp);
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int idle_plan[PHASES];
        int pick;
        idle_plan = '{31, 0, RANDOM_IDLE, 1, RANDOM_IDLE, 31, 0, RANDOM_IDLE};
        rst_n               <= 1'b0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.op           <= OP_CREATE;
        cmd_ch.task_id      <= '0;
        cmd_ch.priority_req <= '0;
        cmd_ch.block_kind   <= ST_BLOCKED;
        cmd_ch.need_switch  <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.idle_task    <= IDLE_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Restate the reset idle task, then walk the special cases
        write_idle(IDLE_RESET);
        directed_walk();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // Reprogram the idle task only once the block has gone quiet
            drain();
            pick = (idle_plan[ph] == RANDOM_IDLE) ? $urandom_range(0, TASKS - 1) : idle_plan[ph];
            write_idle(tid_t'(pick));
            tx_jitter = !(ph == 1 || ph == 5);
            rx_jitter = !(ph == 1 || ph == 6);
            pool_n    = (ph % 3 == 0) ? TASKS : $urandom_range(3, 8);
            pool_base = (ph % 2 == 0) ? pick : $urandom_range(0, TASKS - 1);
            // Stall the response side for a long stretch so the block backs up
            if (ph == 2)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Halt midway and let every outstanding response come home
                if (ph == 4 && i == PHASE_ITEMS / 2)
                    drain();
                send_random();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/rrts_ram.sv
rtl/rrts_task_table.sv
rtl/rrts_queue_cell.sv
rtl/rrts_ready_queue.sv
rtl/round_robin_thread_scheduler.sv
tb/round_robin_thread_scheduler_tb.sv
